// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PSC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("psc assertion failed");

// Condition that must never be true outside reset.
`define PSC_NEVER(label, clk, rst_n, expr) \
    `PSC_ASSERT(label, clk, rst_n, !(expr))

`endif

// File: rtl/core/psc_pkg.sv
// Types, codes and character constants of the polynomial syntax checker.
package psc_pkg;

    // Width of the character position counter.
    localparam int unsigned POS_BITS = 16;
    localparam int unsigned LETTER_COUNT = 26;

    // Character codes the parser recognizes.
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Input commands.
    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } t_cmd;

    // Error codes reported on the output.
    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_TERM_START   = 3'd1,
        ERR_REPEAT_VAR   = 3'd2,
        ERR_AFTER_NUMBER = 3'd3,
        ERR_AFTER_VAR    = 3'd4,
        ERR_NO_EXP_DIGIT = 3'd5
    } t_err;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_SIGN  = 6'b000010,
        PH_COEF  = 6'b000100,
        PH_VAR   = 6'b001000,
        PH_CARET = 6'b010000,
        PH_EXPO  = 6'b100000
    } t_phase;

    // One input transfer.
    typedef struct packed {
        logic       command;
        logic [7:0] character;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic                finished;
        logic [2:0]          error_code;
        logic [POS_BITS-1:0] error_position;
        logic [7:0]          error_character;
    } t_out_item;

    // Parser state carried from one character to the next.
    typedef struct packed {
        t_phase                  phase;
        logic [LETTER_COUNT-1:0] letters;
        logic [POS_BITS-1:0]     char_index;
        t_err                    code;
        logic [POS_BITS-1:0]     position;
        logic [7:0]              chr;
    } t_state;

endpackage

// File: rtl/core/psc_step.sv
// Next-state and result logic for one character or end-of-input item.
module psc_step (
    input  psc_pkg::t_state    i_state,
    input  psc_pkg::t_in_item  i_item,
    output psc_pkg::t_state    o_next,
    output psc_pkg::t_out_item o_result
);
    import psc_pkg::*;

    logic [7:0]              w_c;
    logic                    w_digit;
    logic                    w_letter;
    logic                    w_sign;
    logic [4:0]              w_letter_idx;
    logic [LETTER_COUNT-1:0] w_letter_bit;
    logic                    w_repeat;
    t_err                    w_err;
    t_phase                  w_phase;
    logic [LETTER_COUNT-1:0] w_letters;

    // Character classes.
    assign w_c          = i_item.character;
    assign w_digit      = (w_c >= CH_DIGIT_0) && (w_c <= CH_DIGIT_9);
    assign w_letter     = (w_c >= CH_LOW_A) && (w_c <= CH_LOW_Z);
    assign w_sign       = (w_c == CH_PLUS) || (w_c == CH_MINUS);
    assign w_letter_idx = 5'(w_c - CH_LOW_A);
    assign w_letter_bit = LETTER_COUNT'(1) << w_letter_idx;
    assign w_repeat     = |(i_state.letters & w_letter_bit);

    // Phase transition for a character; an error leaves phase and mask alone.
    always_comb begin
        w_err     = ERR_NONE;
        w_phase   = i_state.phase;
        w_letters = i_state.letters;
        unique case (i_state.phase)
            PH_SIGN, PH_COEF: begin
                if (i_state.phase == PH_COEF && w_sign) begin
                    w_letters = '0;
                    w_phase   = PH_SIGN;
                end else if (w_digit) begin
                    w_phase = PH_COEF;
                end else if (w_letter) begin
                    if (w_repeat) begin
                        w_err = ERR_REPEAT_VAR;
                    end else begin
                        w_letters = i_state.letters | w_letter_bit;
                        w_phase   = PH_VAR;
                    end
                end else begin
                    w_err = (i_state.phase == PH_COEF) ? ERR_AFTER_NUMBER : ERR_TERM_START;
                end
            end
            PH_VAR, PH_EXPO: begin
                if (w_sign) begin
                    w_letters = '0;
                    w_phase   = PH_SIGN;
                end else if (w_letter) begin
                    if (w_repeat) begin
                        w_err = ERR_REPEAT_VAR;
                    end else begin
                        w_letters = i_state.letters | w_letter_bit;
                        w_phase   = PH_VAR;
                    end
                end else if (i_state.phase == PH_VAR && w_c == CH_CARET) begin
                    w_phase = PH_CARET;
                end else if (i_state.phase == PH_EXPO && w_digit) begin
                    w_phase = PH_EXPO;
                end else begin
                    w_err = (i_state.phase == PH_VAR) ? ERR_AFTER_VAR : ERR_AFTER_NUMBER;
                end
            end
            PH_CARET: begin
                if (w_digit) begin
                    w_phase = PH_EXPO;
                end else begin
                    w_err = ERR_NO_EXP_DIGIT;
                end
            end
            default: begin
                // Start of expression; unused codes behave the same way.
                if (w_c == CH_MINUS) begin
                    w_letters = '0;
                    w_phase   = PH_SIGN;
                end else if (w_digit) begin
                    w_phase = PH_COEF;
                end else if (w_letter) begin
                    if (w_repeat) begin
                        w_err = ERR_REPEAT_VAR;
                    end else begin
                        w_letters = i_state.letters | w_letter_bit;
                        w_phase   = PH_VAR;
                    end
                end else begin
                    w_err = ERR_TERM_START;
                end
            end
        endcase
    end

    // State update and result for the item.
    always_comb begin
        t_state l_latched;
        l_latched = i_state;
        o_next    = i_state;
        if (i_item.command == CMD_CHAR) begin
            if (i_state.code == ERR_NONE) begin
                if (w_err != ERR_NONE) begin
                    l_latched.code     = w_err;
                    l_latched.position = i_state.char_index;
                    l_latched.chr      = w_c;
                end else begin
                    l_latched.phase   = w_phase;
                    l_latched.letters = w_letters;
                end
            end
            // The position counter saturates at its top value.
            if (i_state.char_index != '1) begin
                l_latched.char_index = i_state.char_index + 1'b1;
            end
            o_next = l_latched;
        end else begin
            // End of input: check the final phase, then return to reset.
            if (i_state.code == ERR_NONE) begin
                if (i_state.phase == PH_CARET) begin
                    l_latched.code     = ERR_NO_EXP_DIGIT;
                    l_latched.position = i_state.char_index;
                    l_latched.chr      = CH_SPACE;
                end else if (i_state.phase != PH_COEF && i_state.phase != PH_VAR &&
                             i_state.phase != PH_EXPO) begin
                    l_latched.code     = ERR_TERM_START;
                    l_latched.position = i_state.char_index;
                    l_latched.chr      = CH_SPACE;
                end
            end
            o_next.phase      = PH_START;
            o_next.letters    = '0;
            o_next.char_index = '0;
            o_next.code       = ERR_NONE;
            o_next.position   = '0;
            o_next.chr        = '0;
        end
        o_result.finished        = (i_item.command == CMD_END);
        o_result.error_code      = l_latched.code;
        o_result.error_position  = l_latched.position;
        o_result.error_character = l_latched.chr;
    end

endmodule

// File: rtl/core/polynomial_syntax_checker_unit.sv
// Polynomial syntax checker top level: parser state plus a two-entry result buffer.
// A result is registered into the output register, or into the skid register while the output register is full.
// Throughput: one character or end-of-input item per cycle while the skid register is empty.
// The result register and a skid register let input transfers continue while a result waits.
// Reset (synchronous, active low) clears the parser state and empties the result buffer.
module polynomial_syntax_checker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  psc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output psc_pkg::t_out_item o_out_data
);
    import psc_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_item w_result;
    t_out_item r_out;
    t_out_item n_out;
    t_out_item r_skid;
    t_out_item n_skid;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      r_skid_valid;
    logic      n_skid_valid;
    logic      w_in_xfer;
    logic      w_out_xfer;

    // Per-item parser logic.
    psc_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_next   (n_state),
        .o_result (w_result)
    );

    assign o_in_ready  = !r_skid_valid;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_xfer  = r_out_valid && i_out_ready;

    // Parser state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_START;
            r_state.letters    <= '0;
            r_state.char_index <= '0;
            r_state.code       <= ERR_NONE;
            r_state.position   <= '0;
            r_state.chr        <= '0;
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    // Result buffer: the skid entry refills the output register when it drains.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_out_xfer) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_in_xfer) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = w_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

`include "assert_macros.svh"

    // The skid entry is only ever filled behind a full output register.
    `PSC_NEVER(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)

    // An end-of-input transfer returns the parser to its reset state.
    `PSC_ASSERT(a_end_resets, i_clk, i_rst_n,
        (w_in_xfer && i_in_data.command == CMD_END) |=>
        (r_state.phase == PH_START && r_state.letters == '0 &&
         r_state.char_index == '0 && r_state.code == ERR_NONE))

    // A latched error stays put while further characters arrive.
    `PSC_ASSERT(a_error_sticky, i_clk, i_rst_n,
        (w_in_xfer && i_in_data.command == CMD_CHAR && r_state.code != ERR_NONE) |=>
        (r_state.code == $past(r_state.code) && r_state.position == $past(r_state.position)))

    // Every input transfer leaves a result waiting in the next cycle.
    `PSC_ASSERT(a_result_follows, i_clk, i_rst_n, w_in_xfer |=> r_out_valid)

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the polynomial syntax checker unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int TAIL_ITEMS     = 200;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 40;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // Items still to be offered, and results still to arrive, in order.
    t_in_item  char_stream[$];
    t_out_item awaited_results[$];

    int items_sent   = 0;
    int results_seen = 0;
    int total_items  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    // Parser state kept by the predictor.
    t_phase              term_phase;
    logic [25:0]         term_letters;
    logic [POS_BITS-1:0] next_pos;
    t_err                held_code;
    logic [POS_BITS-1:0] held_pos;
    logic [7:0]          held_char;

    // Sender and receiver pacing.
    int gap_left      = 0;
    int send_gap_pct  = 0;
    int stall_left    = 0;
    int stall_pct     = 0;
    int recv_cycles   = 0;
    int holdoff_left  = 0;
    bit holdoff_done  = 1'b0;

    polynomial_syntax_checker_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Returns the parser to the start of an expression.
    function automatic void clear_parser();
        term_phase   = PH_START;
        term_letters = '0;
        next_pos     = '0;
        held_code    = ERR_NONE;
        held_pos     = '0;
        held_char    = '0;
    endfunction

    // Advances the parser by one character and returns the error it causes.
    function automatic t_err parse_symbol(input logic [7:0] c);
        logic        is_dig;
        logic        is_let;
        logic        is_sgn;
        logic [25:0] letter_bit;
        t_err        e;
        is_dig = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
        is_let = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
        is_sgn = (c == CH_PLUS) || (c == CH_MINUS);
        letter_bit = is_let ? (26'd1 << (c - CH_LOW_A)) : '0;
        e = ERR_NONE;
        case (term_phase)
            PH_SIGN, PH_COEF: begin
                if (term_phase == PH_COEF && is_sgn) begin
                    term_letters = '0;
                    term_phase = PH_SIGN;
                end else if (is_dig) begin
                    term_phase = PH_COEF;
                end else if (is_let) begin
                    if ((term_letters & letter_bit) != '0) begin
                        e = ERR_REPEAT_VAR;
                    end else begin
                        term_letters = term_letters | letter_bit;
                        term_phase = PH_VAR;
                    end
                end else begin
                    e = (term_phase == PH_COEF) ? ERR_AFTER_NUMBER : ERR_TERM_START;
                end
            end
            PH_VAR, PH_EXPO: begin
                if (is_sgn) begin
                    term_letters = '0;
                    term_phase = PH_SIGN;
                end else if (is_let) begin
                    if ((term_letters & letter_bit) != '0) begin
                        e = ERR_REPEAT_VAR;
                    end else begin
                        term_letters = term_letters | letter_bit;
                        term_phase = PH_VAR;
                    end
                end else if (term_phase == PH_VAR && c == CH_CARET) begin
                    term_phase = PH_CARET;
                end else if (term_phase == PH_EXPO && is_dig) begin
                    term_phase = PH_EXPO;
                end else begin
                    e = (term_phase == PH_VAR) ? ERR_AFTER_VAR : ERR_AFTER_NUMBER;
                end
            end
            PH_CARET: begin
                if (is_dig) begin
                    term_phase = PH_EXPO;
                end else begin
                    e = ERR_NO_EXP_DIGIT;
                end
            end
            default: begin
                // Start of an expression: a leading minus is allowed, a plus is not.
                if (c == CH_MINUS) begin
                    term_letters = '0;
                    term_phase = PH_SIGN;
                end else if (is_dig) begin
                    term_phase = PH_COEF;
                end else if (is_let) begin
                    if ((term_letters & letter_bit) != '0) begin
                        e = ERR_REPEAT_VAR;
                    end else begin
                        term_letters = term_letters | letter_bit;
                        term_phase = PH_VAR;
                    end
                end else begin
                    e = ERR_TERM_START;
                end
            end
        endcase
        return e;
    endfunction

    // Works out the result of one accepted item and updates the parser state.
    function automatic t_out_item syntax_result(input t_in_item it);
        t_out_item r;
        t_err      e;
        if (it.command == CMD_CHAR) begin
            if (held_code == ERR_NONE) begin
                e = parse_symbol(it.character);
                if (e != ERR_NONE) begin
                    held_code = e;
                    held_pos  = next_pos;
                    held_char = it.character;
                end
            end
            if (next_pos != '1) begin
                next_pos = next_pos + 1'b1;
            end
            r.finished = 1'b0;
        end else begin
            // End of input: an empty text, a dangling sign or a dangling caret fails.
            if (held_code == ERR_NONE) begin
                e = ERR_NONE;
                if (term_phase == PH_START || term_phase == PH_SIGN) begin
                    e = ERR_TERM_START;
                end else if (term_phase == PH_CARET) begin
                    e = ERR_NO_EXP_DIGIT;
                end
                if (e != ERR_NONE) begin
                    held_code = e;
                    held_pos  = next_pos;
                    held_char = CH_SPACE;
                end
            end
            r.finished = 1'b1;
        end
        r.error_code      = held_code;
        r.error_position  = held_pos;
        r.error_character = held_char;
        if (it.command == CMD_END) begin
            clear_parser();
        end
        return r;
    endfunction

    // Picks how often one side idles over the next stretch.
    function automatic int idle_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 45;
        endcase
    endfunction

    task automatic queue_char(input logic [7:0] c);
        t_in_item it;
        it.command   = CMD_CHAR;
        it.character = c;
        char_stream = {char_stream, it};
    endtask

    // The character field is a don't-care on end of input, so it is random.
    task automatic queue_end();
        t_in_item it;
        it.command   = CMD_END;
        it.character = 8'($urandom_range(0, 255));
        char_stream = {char_stream, it};
    endtask

    task automatic queue_text(input string s);
        foreach (s[i]) begin
            queue_char(s[i]);
        end
    endtask

    // One random expression: mostly well formed, some corrupted, some pure noise.
    task automatic queue_expression();
        logic [7:0]  txt[$];
        logic [25:0] seen;
        int          mode;
        int          terms;
        int          n;
        int          k;
        int          v;
        mode = $urandom_range(0, 99);
        if (mode < 15) begin
            n = $urandom_range(0, 6);
            repeat (n) txt = {txt, 8'($urandom_range(0, 255))};
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                txt = {txt, CH_MINUS};
            end
            terms = $urandom_range(1, 4);
            for (int t = 0; t < terms; t++) begin
                if (t > 0) begin
                    txt = {txt, ($urandom_range(0, 1) ? CH_PLUS : CH_MINUS)};
                end
                seen = '0;
                n = $urandom_range(0, 3);
                repeat (n) txt = {txt, 8'(CH_DIGIT_0 + $urandom_range(0, 9))};
                k = $urandom_range(0, 3);
                if (n == 0 && k == 0) begin
                    k = 1;
                end
                repeat (k) begin
                    v = $urandom_range(0, 25);
                    // Now and then a variable is allowed to repeat within its term.
                    if ($urandom_range(0, 9) != 0) begin
                        while (seen[v]) v = (v + 1) % 26;
                    end
                    seen[v] = 1'b1;
                    txt = {txt, 8'(CH_LOW_A + v)};
                    if ($urandom_range(0, 1)) begin
                        txt = {txt, CH_CARET};
                        repeat ($urandom_range(1, 2)) begin
                            txt = {txt, 8'(CH_DIGIT_0 + $urandom_range(0, 9))};
                        end
                    end
                end
            end
            // Break some of the well-formed texts.
            if (mode < 40) begin
                case ($urandom_range(0, 3))
                    0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                    1: txt = {txt, ($urandom_range(0, 1) ? CH_PLUS : CH_MINUS)};
                    2: txt = {txt, CH_CARET};
                    default: begin
                        n = $urandom_range(0, txt.size() - 1);
                        while (txt.size() > n) void'(txt.pop_back());
                    end
                endcase
            end
        end
        foreach (txt[i]) begin
            queue_char(txt[i]);
        end
        queue_end();
    endtask

    // Driver: offers the pending items, holding each until its transfer.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                awaited_results = {awaited_results, syntax_result(in_data)};
                items_sent <= items_sent + 1;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (char_stream.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= char_stream.pop_front();
                    if (char_stream.size() % 64 == 0) begin
                        send_gap_pct = idle_rate();
                    end
                    if (char_stream.size() >= TAIL_ITEMS &&
                            $urandom_range(0, 99) < send_gap_pct) begin
                        gap_left = $urandom_range(1, 14);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the input.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            recv_cycles++;
            if (recv_cycles % 64 == 0) begin
                stall_pct = idle_rate();
            end
            if (items_sent + TAIL_ITEMS < total_items && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic report_field(input string field, input int unsigned want, input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (awaited_results.size() == 0) begin
                report_field("unexpected result, error_code", 0, out_data.error_code);
            end else begin
                want = awaited_results.pop_front();
                if (out_data.finished !== want.finished) begin
                    report_field("finished", want.finished, out_data.finished);
                end
                if (out_data.error_code !== want.error_code) begin
                    report_field("error_code", want.error_code, out_data.error_code);
                end
                if (out_data.error_position !== want.error_position) begin
                    report_field("error_position", want.error_position, out_data.error_position);
                end
                if (out_data.error_character !== want.error_character) begin
                    report_field("error_character", want.error_character,
                                 out_data.error_character);
                end
            end
        end
    end

    // Watchdog: ends a run in which no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[polynomial_syntax_checker_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int mark;
        int random_count;
        clear_parser();

        // Directed texts: field extremes and end of input in the start, sign, caret and coefficient phases.
        queue_end();
        queue_char(CH_MINUS);
        queue_end();
        queue_char(CH_LOW_Z);
        queue_char(CH_CARET);
        queue_end();
        queue_char(CH_PLUS);
        queue_end();
        queue_char(CH_LOW_A);
        queue_char(CH_LOW_A);
        queue_end();
        queue_char(CH_DIGIT_0);
        queue_char(8'h00);
        queue_char(CH_LOW_A);
        queue_end();
        queue_text("-a^9b");
        queue_char(8'hFF);
        queue_end();
        queue_text("9z^0-1");
        queue_end();

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            mark = char_stream.size();
            queue_expression();
            random_count += char_stream.size() - mark;
        end
        total_items = char_stream.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (char_stream.size() != 0 || in_valid || awaited_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[polynomial_syntax_checker_unit] OK");
        end else begin
            $display("[polynomial_syntax_checker_unit] ERROR");
        end
        $finish;
    end

endmodule
